/* rtl/sdd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdd_pkg
// Shared types, constants and helpers for the signed decimal divider.
// ----------------------------------------------------------------------------
package sdd_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int MAX_DIGITS_DEF = 6;

  localparam int IN_W        = 32;
  localparam int OUT_W       = 52;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_W       = 3;

  localparam logic [CFG_W-1:0] CFG_RESET = 3'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIVIDE,
    ST_FINISH
  } sdd_state_t;

  typedef struct packed {
    logic load;
    logic scale;
    logic divide;
    logic finish;
  } sdd_ctl_t;

  function automatic longint pow10(input int n);
    longint p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

endpackage
`default_nettype wire

/* rtl/sdd_alu.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdd_alu
// Shared adder/subtractor used for both decimal scaling and division steps.
// ----------------------------------------------------------------------------
module sdd_alu #(
  parameter int AW = 53
) (
  input  wire logic [AW-1:0] op_a,
  input  wire logic [AW-1:0] op_b,
  input  wire logic          sub,
  output logic      [AW-1:0] res
);

  logic [AW-1:0] b_eff;

  assign b_eff = sub ? ~op_b : op_b;
  assign res   = op_a + b_eff + AW'(sub);

endmodule
`default_nettype wire

/* rtl/sdd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdd_ctrl
// Sequencer: accept, scale by ten per digit, one quotient bit per step, finish.
// ----------------------------------------------------------------------------
module sdd_ctrl #(
  parameter int NW = 52
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic                      div_zero,
  input  wire logic [sdd_pkg::CFG_W-1:0] digits,
  input  wire logic                      out_busy,
  output logic                           in_ready,
  output sdd_pkg::sdd_ctl_t              ctl
);
  import sdd_pkg::*;

  localparam int CW = $clog2(NW);

  sdd_state_t      state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (div_zero) begin
            state_nxt = ST_FINISH;
          end else if (digits == '0) begin
            state_nxt = ST_DIVIDE;
            cnt_nxt   = CW'(NW - 1);
          end else begin
            state_nxt = ST_SCALE;
            cnt_nxt   = CW'(digits) - CW'(1);
          end
        end
      end
      ST_SCALE: begin
        if (cnt_r == '0) begin
          state_nxt = ST_DIVIDE;
          cnt_nxt   = CW'(NW - 1);
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      ST_DIVIDE: begin
        if (cnt_r == '0) begin
          state_nxt = ST_FINISH;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      ST_FINISH: begin
        if (!out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    ctl        = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      ST_SCALE: begin
        ctl.scale = 1'b1;
      end
      ST_DIVIDE: begin
        ctl.divide = 1'b1;
      end
      ST_FINISH: begin
        ctl.finish = !out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/signed_decimal_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_decimal_divider
// Signed divide giving the quotient scaled by ten to a configured digit count.
// ----------------------------------------------------------------------------
// One word is taken at a time. After acceptance the dividend magnitude is
// multiplied by ten once per fraction digit, then divided by the divisor
// magnitude one quotient bit per cycle, both on a single shared adder. The
// scaled quotient is NW bits wide, DATA_WIDTH plus the bits of ten to
// MAX_DIGITS. A zero divisor skips scaling and division and goes straight
// to the final step. A stalled earlier result holds the final step.
// in_tready is low while busy.
// The result is truncated toward zero; fraction_digits above MAX_DIGITS
// saturates. A zero divisor returns zero with the flag set.
// ----------------------------------------------------------------------------
module signed_decimal_divider #(
  parameter int DATA_WIDTH = sdd_pkg::DATA_WIDTH_DEF,
  parameter int MAX_DIGITS = sdd_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // dividend [31:0], divisor [63:32]
  input  wire logic [2*sdd_pkg::IN_W-1:0]      in_tdata,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // quotient_scaled [51:0], zero pad [55:52]
  output logic [sdd_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // divide_by_zero [0]
  output logic                                 out_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic                            cfg_we,
  input  wire logic [sdd_pkg::CFG_W-1:0]       cfg_wdata
);
  import sdd_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int NW = DATA_WIDTH + $clog2(pow10(MAX_DIGITS));
  localparam int AW = NW + 1;

  logic [CFG_W-1:0] digits_r;
  logic [CFG_W-1:0] digits_sat;

  logic [W-1:0]     raw_a, raw_b;
  logic [W-1:0]     mag_a, mag_b;
  logic             sgn_a, sgn_b;
  logic             div_zero;

  logic [NW-1:0]    nq_r, nq_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     dvs_r;
  logic             neg_r, dz_r;

  logic [W:0]       rem_sh;
  logic [AW-1:0]    op_a, op_b, alu_res;
  logic             alu_sub;

  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_q_r, out_q_nxt;
  logic                 out_dz_r;
  logic [OUT_W-1:0]     q_mag;

  sdd_ctl_t ctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r <= CFG_RESET;
    end else if (cfg_we) begin
      digits_r <= cfg_wdata;
    end
  end

  assign digits_sat = (digits_r > CFG_W'(MAX_DIGITS)) ? CFG_W'(MAX_DIGITS) : digits_r;

  assign raw_a    = in_tdata[W-1:0];
  assign raw_b    = in_tdata[IN_W+W-1:IN_W];
  assign sgn_a    = raw_a[W-1];
  assign sgn_b    = raw_b[W-1];
  assign mag_a    = sgn_a ? (~raw_a + W'(1)) : raw_a;
  assign mag_b    = sgn_b ? (~raw_b + W'(1)) : raw_b;
  assign div_zero = (raw_b == '0);

  sdd_ctrl #(
    .NW(NW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .div_zero (div_zero),
    .digits   (digits_sat),
    .out_busy (out_valid_r && !out_tready),
    .in_ready (in_tready),
    .ctl      (ctl)
  );

  assign rem_sh = {rem_r, nq_r[NW-1]};

  always_comb begin
    if (ctl.scale) begin
      op_a    = AW'(nq_r) << 3;
      op_b    = AW'(nq_r) << 1;
      alu_sub = 1'b0;
    end else begin
      op_a    = AW'(rem_sh);
      op_b    = AW'(dvs_r);
      alu_sub = 1'b1;
    end
  end

  sdd_alu #(
    .AW(AW)
  ) u_alu (
    .op_a (op_a),
    .op_b (op_b),
    .sub  (alu_sub),
    .res  (alu_res)
  );

  always_comb begin
    nq_nxt  = nq_r;
    rem_nxt = rem_r;
    if (ctl.load) begin
      nq_nxt  = NW'(mag_a);
      rem_nxt = '0;
    end else if (ctl.scale) begin
      nq_nxt = alu_res[NW-1:0];
    end else if (ctl.divide) begin
      if (!alu_res[AW-1]) begin
        rem_nxt = alu_res[W-1:0];
        nq_nxt  = {nq_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[W-1:0];
        nq_nxt  = {nq_r[NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    nq_r  <= nq_nxt;
    rem_r <= rem_nxt;
    if (ctl.load) begin
      dvs_r <= mag_b;
      neg_r <= sgn_a ^ sgn_b;
      dz_r  <= div_zero;
    end
  end

  assign q_mag = OUT_W'(nq_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_q_nxt     = out_q_r;
    if (ctl.finish) begin
      out_valid_nxt = 1'b1;
      if (dz_r) begin
        out_q_nxt = '0;
      end else if (neg_r) begin
        out_q_nxt = ~q_mag + OUT_W'(1);
      end else begin
        out_q_nxt = q_mag;
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_q_r <= out_q_nxt;
    if (ctl.finish) begin
      out_dz_r <= dz_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_q_r);
  assign out_tuser  = out_dz_r;

endmodule
`default_nettype wire

/* rtl/sdd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdd_checker
// Port-level checks for the signed decimal divider, bound to the top level.
// ----------------------------------------------------------------------------
module sdd_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic [2*sdd_pkg::IN_W-1:0]          in_tdata,
  input wire logic                                in_tvalid,
  input wire logic                                in_tready,
  input wire logic [sdd_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input wire logic                                out_tuser,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic                                cfg_we,
  input wire logic [sdd_pkg::CFG_W-1:0]           cfg_wdata
);
  import sdd_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{in_tdata, cfg_we, cfg_wdata};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while busy");

  a_zero_flag_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[OUT_W-1:0] == '0)
    else $error("divide by zero result not zero");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:OUT_W] == '0)
    else $error("result padding not zero");

endmodule

bind signed_decimal_divider sdd_checker u_sdd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tdata   (in_tdata),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .cfg_we     (cfg_we),
  .cfg_wdata  (cfg_wdata)
);
`default_nettype wire
